@@ rtl/core/ksa_pkg.sv @@
package ksa_pkg;

  // Table geometry and field widths.
  localparam int SLOTS   = 16;
  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 5;
  localparam int KEY_W   = 32;
  localparam int OP_W    = 3;

  // Request codes.
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC         = 3'd0,
    OP_RELEASE       = 3'd1,
    OP_RELEASE_MATCH = 3'd2,
    OP_RELEASE_ALL   = 3'd3,
    OP_COUNT         = 3'd4,
    OP_NTH           = 3'd5,
    OP_FIND          = 3'd6
  } op_t;

  // One registered request.
  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [KEY_W-1:0]  key;
    logic              kind_flag;
    logic [SLOT_W-1:0] slot_index;
    logic [SLOT_W-1:0] nth_index;
  } req_t;

  // Table update produced by the execute logic.
  typedef struct packed {
    logic              set_en;
    logic [SLOT_W-1:0] set_idx;
    logic [KEY_W-1:0]  set_key;
    logic              set_kind;
    logic [SLOTS-1:0]  clear_mask;
  } upd_t;

  // Table status seen by the execute logic.
  typedef struct packed {
    logic [SLOTS-1:0] occupied;
    logic [SLOTS-1:0] match_vec;
  } tbl_stat_t;

  // One result.
  typedef struct packed {
    logic               ok;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] occupied_count;
  } res_t;

endpackage

@@ rtl/core/keyed_slot_allocator_top.sv @@
// Each request passes the request register, then the result register, which raises done with it.
// Throughput: one request per cycle; busy is always low, as compare, priority encode and
// population count over the sixteen register entries fit between the request and result registers.
// Reset (rst, synchronous, active high) frees every slot and drops done.
// The receiver cannot stall: each result is shown for exactly one cycle.
module keyed_slot_allocator_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [ksa_pkg::OP_W-1:0]     operation,
  input  logic [ksa_pkg::KEY_W-1:0]    key,
  input  logic                         kind_flag,
  input  logic [ksa_pkg::SLOT_W-1:0]   slot_index,
  input  logic [ksa_pkg::SLOT_W-1:0]   nth_index,
  output logic                         done,
  output logic                         ok,
  output logic [ksa_pkg::SLOT_W-1:0]   slot,
  output logic [ksa_pkg::COUNT_W-1:0]  occupied_count
);
  import ksa_pkg::*;

  logic      req_valid;
  req_t      req;
  upd_t      upd;
  tbl_stat_t stat;
  res_t      res;

  assign busy = 1'b0;

  // Request register: captures each transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req.operation  <= operation;
      req.key        <= key;
      req.kind_flag  <= kind_flag;
      req.slot_index <= slot_index;
      req.nth_index  <= nth_index;
    end
  end

  ksa_table u_table (
    .clk      (clk),
    .rst      (rst),
    .cmp_key  (req.key),
    .cmp_kind (req.kind_flag),
    .upd      (upd),
    .stat     (stat)
  );

  ksa_exec u_exec (
    .valid (req_valid),
    .req   (req),
    .stat  (stat),
    .upd   (upd),
    .res   (res)
  );

  // Result register: one strobed result per request.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    ok             <= res.ok;
    slot           <= res.slot;
    occupied_count <= res.occupied_count;
  end

endmodule

@@ rtl/core/ksa_table.sv @@
module ksa_table (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [ksa_pkg::KEY_W-1:0]  cmp_key,
  input  logic                       cmp_kind,
  input  ksa_pkg::upd_t              upd,
  output ksa_pkg::tbl_stat_t         stat
);
  import ksa_pkg::*;

  logic [SLOTS-1:0] occupied;
  logic [KEY_W-1:0] slot_keys [SLOTS];
  logic             slot_kinds [SLOTS];

  // Occupied bits: set on allocation, cleared on release.
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= '0;
    end else begin
      occupied <= (occupied | (upd.set_en ? (SLOTS'(1) << upd.set_idx) : '0))
                  & ~upd.clear_mask;
    end
  end

  // Key and kind storage, written on allocation only; a free entry is never matched.
  always_ff @(posedge clk) begin
    if (upd.set_en) begin
      slot_keys[upd.set_idx]  <= upd.set_key;
      slot_kinds[upd.set_idx] <= upd.set_kind;
    end
  end

  // Parallel compare of every occupied entry against the request.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      stat.match_vec[i] = occupied[i] && (slot_keys[i] == cmp_key)
                          && (slot_kinds[i] == cmp_kind);
    end
    stat.occupied = occupied;
  end

endmodule

@@ rtl/core/ksa_exec.sv @@
module ksa_exec (
  input  logic               valid,
  input  ksa_pkg::req_t      req,
  input  ksa_pkg::tbl_stat_t stat,
  output ksa_pkg::upd_t      upd,
  output ksa_pkg::res_t      res
);
  import ksa_pkg::*;

  logic                alloc_found;
  logic [SLOT_W-1:0]   alloc_idx;
  logic                match_found;
  logic [SLOT_W-1:0]   match_idx;
  logic [SLOTS-1:0]    nth_hit;
  logic                nth_found;
  logic [SLOT_W-1:0]   nth_idx;
  logic [SLOTS-1:0]    mask_next;
  logic                ok;
  logic [SLOT_W-1:0]   slot;

  // Lowest free slot and lowest matching slot.
  always_comb begin
    alloc_found = 1'b0;
    alloc_idx   = '0;
    match_found = 1'b0;
    match_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!stat.occupied[i]) begin
        alloc_found = 1'b1;
        alloc_idx   = SLOT_W'(i);
      end
      if (stat.match_vec[i]) begin
        match_found = 1'b1;
        match_idx   = SLOT_W'(i);
      end
    end
  end

  // A slot is the n-th occupied one when it is occupied and exactly n occupied slots lie below.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      nth_hit[i] = stat.occupied[i]
                   && (COUNT_W'($countones(stat.occupied & ((SLOTS'(1) << i) - SLOTS'(1))))
                       == {1'b0, req.nth_index});
    end
    nth_found = |nth_hit;
    nth_idx   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (nth_hit[i]) begin
        nth_idx = SLOT_W'(i);
      end
    end
  end

  // Decode the request into a table update and a result.
  always_comb begin
    upd.set_en     = 1'b0;
    upd.set_idx    = alloc_idx;
    upd.set_key    = req.key;
    upd.set_kind   = req.kind_flag;
    upd.clear_mask = '0;
    ok             = 1'b0;
    slot           = '0;
    case (op_t'(req.operation))
      OP_ALLOC: begin
        if (alloc_found) begin
          upd.set_en = valid;
          ok         = 1'b1;
          slot       = alloc_idx;
        end
      end
      OP_RELEASE: begin
        if ((int'(req.slot_index) < SLOTS) && stat.occupied[req.slot_index]) begin
          upd.clear_mask = valid ? (SLOTS'(1) << req.slot_index) : '0;
          ok             = 1'b1;
          slot           = req.slot_index;
        end
      end
      OP_RELEASE_MATCH: begin
        if (match_found) begin
          upd.clear_mask = valid ? (SLOTS'(1) << match_idx) : '0;
          ok             = 1'b1;
          slot           = match_idx;
        end
      end
      OP_RELEASE_ALL: begin
        upd.clear_mask = valid ? '1 : '0;
        ok             = 1'b1;
      end
      OP_COUNT: begin
        ok = 1'b1;
      end
      OP_NTH: begin
        if (nth_found) begin
          ok   = 1'b1;
          slot = nth_idx;
        end
      end
      OP_FIND: begin
        if (match_found) begin
          ok   = 1'b1;
          slot = match_idx;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // Occupancy after this step.
  always_comb begin
    mask_next = (stat.occupied | (upd.set_en ? (SLOTS'(1) << upd.set_idx) : '0))
                & ~upd.clear_mask;
    res.ok             = ok;
    res.slot           = slot;
    res.occupied_count = COUNT_W'($countones(mask_next));
  end

endmodule
